// ----- rtl/cfws_pkg.sv -----
// shared types and codes for the circular fifo with search
// no dependencies
`default_nettype none

package cfws_pkg;

    localparam int unsigned CAP_W     = 7;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned CAP_RESET = 64;

    typedef enum logic [1:0] {
        K_PUSH = 2'd0,
        K_POP  = 2'd1,
        K_FIND = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status             status;
        logic [WORD_W-1:0]   value;
        logic [IDX_W-1:0]    index;
        logic                empty;
        logic                full;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/cfws_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module cfws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/cfws_seq.sv -----
// sequencer: ring pointers, wrap flag, capacity limit and the shared compare step
// depends on cfws_pkg; drives the ports of one cfws_ram
`default_nettype none

module cfws_seq #(
    parameter int DEPTH = 64,
    localparam int PW = $clog2(DEPTH)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_kind,
    input  wire logic [cfws_pkg::WORD_W-1:0]  i_data,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [cfws_pkg::CAP_W-1:0]   i_cfg_data,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output cfws_pkg::t_result                 o_res,
    output logic                              o_mem_we,
    output logic [PW-1:0]                     o_mem_waddr,
    output logic [cfws_pkg::WORD_W-1:0]       o_mem_wdata,
    output logic [PW-1:0]                     o_mem_raddr,
    input  wire logic [cfws_pkg::WORD_W-1:0]  i_mem_rdata
);

    import cfws_pkg::*;

    localparam int LW      = (PW + 1 > CAP_W) ? PW + 1 : CAP_W;
    localparam int XW      = (PW > IDX_W) ? PW : IDX_W;
    localparam int RST_CAP = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;
    localparam logic [PW-1:0] RST_LAST = PW'(RST_CAP - 1);

    t_state              r_state, n_state;
    t_kind               r_kind, n_kind;
    logic [WORD_W-1:0]   r_data, n_data;
    logic [PW-1:0]       r_head, n_head;
    logic [PW-1:0]       r_tail, n_tail;
    logic                r_nw, n_nw;
    logic [PW-1:0]       r_last, n_last;
    logic [PW-1:0]       r_cur, n_cur;
    t_status             r_status, n_status;
    logic [WORD_W-1:0]   r_value, n_value;
    logic [PW-1:0]       r_idx, n_idx;

    logic                in_acc, cfg_acc;
    logic                empty_w, full_w;
    logic [PW-1:0]       adv_head, adv_tail, adv_cur;
    logic [LW-1:0]       cap_x;
    logic [PW-1:0]       cfg_last;
    logic                hit;
    logic [XW-1:0]       idx_x;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] pos, input logic [PW-1:0] last);
        return (pos == last) ? '0 : pos + 1'b1;
    endfunction

    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign empty_w  = (r_head == r_tail) && r_nw;
    assign full_w   = (r_head == r_tail) && !r_nw;
    assign adv_head = adv(r_head, r_last);
    assign adv_tail = adv(r_tail, r_last);
    assign adv_cur  = adv(r_cur, r_last);
    assign hit      = (i_mem_rdata == r_data);

    // effective capacity minus one, clamped to 1..DEPTH
    assign cap_x = LW'(i_cfg_data);
    always_comb begin
        priority if (cap_x == '0) begin
            cfg_last = '0;
        end else if (cap_x > LW'(DEPTH)) begin
            cfg_last = PW'(DEPTH - 1);
        end else begin
            cfg_last = PW'(cap_x - 1'b1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_kind)
                    K_POP:   n_state = empty_w ? S_DONE : S_RD;
                    K_FIND:  n_state = empty_w ? S_DONE : S_RD;
                    default: n_state = S_DONE;
                endcase
            end
            S_RD: begin
                if (r_kind == K_POP || hit || adv_cur == r_tail) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_kind      = r_kind;
        n_data      = r_data;
        n_head      = r_head;
        n_tail      = r_tail;
        n_nw        = r_nw;
        n_last      = r_last;
        n_cur       = r_cur;
        n_status    = r_status;
        n_value     = r_value;
        n_idx       = r_idx;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_tail;
        o_mem_wdata = r_data;
        o_mem_raddr = (r_state == S_RD) ? adv_cur : r_head;
        o_in_ready  = (r_state == S_IDLE);
        o_cfg_ready = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind = t_kind'(i_kind);
                    n_data = i_data;
                end
                if (cfg_acc) begin
                    n_head = '0;
                    n_tail = '0;
                    n_nw   = 1'b1;
                    n_last = cfg_last;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_value  = '0;
                n_idx    = '0;
                n_cur    = r_head;
                unique case (r_kind)
                    K_PUSH: begin
                        if (full_w) begin
                            n_status = ST_FULL;
                        end else begin
                            o_mem_we = 1'b1;
                            n_tail   = adv_tail;
                            if (r_head == adv_tail) begin
                                n_nw = 1'b0;
                            end
                        end
                    end
                    K_POP: begin
                        if (empty_w) begin
                            n_status = ST_EMPTY;
                        end
                    end
                    K_FIND: begin
                        if (empty_w) begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    default: ;
                endcase
            end
            S_RD: begin
                if (r_kind == K_POP) begin
                    n_value = i_mem_rdata;
                    n_head  = adv_head;
                    if (adv_head == r_tail) begin
                        n_nw = 1'b1;
                    end
                end else if (hit) begin
                    n_idx = r_cur;
                end else if (adv_cur == r_tail) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_cur = adv_cur;
                end
            end
            default: ;
        endcase
    end

    assign idx_x        = XW'(r_idx);
    assign o_res.status = r_status;
    assign o_res.value  = r_value;
    assign o_res.index  = idx_x[IDX_W-1:0];
    assign o_res.empty  = empty_w;
    assign o_res.full   = full_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_nw    <= 1'b1;
            r_last  <= RST_LAST;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_nw    <= n_nw;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_data   <= n_data;
        r_cur    <= n_cur;
        r_status <= n_status;
        r_value  <= n_value;
        r_idx    <= n_idx;
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= r_last) && (r_tail <= r_last))
        else $error("ring pointer beyond capacity");

    a_push_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_kind == K_PUSH && !full_w) |=> !empty_w)
        else $error("queue empty after stored word");

    a_pop_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD && r_kind == K_POP) |=> !full_w)
        else $error("queue full after pop");

    a_notfound_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_NOTFOUND) |-> (r_kind == K_FIND))
        else $error("not-found status on a non-find word");

endmodule

`default_nettype wire

// ----- rtl/circular_fifo_with_search_unit.sv -----
// top level: sequencer, word store and the output register
// depends on cfws_pkg, cfws_ram, cfws_seq
`default_nettype none

// Ring-buffer fifo of 32-bit words with push, pop and find. One word is taken
// at a time; a push or an unused kind passes the execute and done states, a pop
// execute, read and done (execute and done on an empty queue), and a find
// execute, one read step per occupied entry compared, and done. The result is
// loaded into the output register as the sequencer returns to idle. The find
// walks the ring from head to tail through the single read port of the store,
// one compare per cycle. A result sits in an output register, so the next word
// can be taken while it waits; a second result then holds in the sequencer's
// done state until the output register frees. Writing the capacity register
// empties the queue; 0 acts as 1 and values above DEPTH act as DEPTH.
module circular_fifo_with_search_unit #(
    parameter int DEPTH = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_kind,
    input  wire logic signed [31:0]           i_data,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [cfws_pkg::CAP_W-1:0]   i_cfg_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [1:0]                        o_status,
    output logic signed [31:0]                o_value,
    output logic [cfws_pkg::IDX_W-1:0]        o_index,
    output logic                              o_empty_res,
    output logic                              o_full_res
);

    import cfws_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic              res_valid, res_ready;
    t_result           res;
    logic              mem_we;
    logic [PW-1:0]     mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;
    logic              r_out_valid, n_out_valid;
    t_result           r_out;

    cfws_seq #(.DEPTH(DEPTH)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_data      (i_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    cfws_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register
    assign res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_value     = r_out.value;
    assign o_index     = r_out.index;
    assign o_empty_res = r_out.empty;
    assign o_full_res  = r_out.full;

endmodule

`default_nettype wire
